// ----- rtl/indexed_color_frame_buffer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the indexed color frame buffer
// Shorthand for clocked implication checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_COLOR_FRAME_BUFFER_ASSERT_SVH
`define INDEXED_COLOR_FRAME_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICFB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ICFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame buffer check failed");

`endif

// ----- rtl/icfb_pkg.sv -----
// ---------------------------------------------------------------------------
// icfb_pkg
// Field widths, command codes and register indexes of the frame buffer.
// ---------------------------------------------------------------------------
package icfb_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int PIXIDX_W = 4;
  localparam int COLOR_W  = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_END    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

endpackage

// ----- rtl/indexed_color_frame_buffer.sv -----
// ---------------------------------------------------------------------------
// indexed_color_frame_buffer
// Column-major packed pixel store with a small palette, one request at a time.
// ---------------------------------------------------------------------------
// End and unknown codes go straight to the result; put reads the pixel word,
// then writes it back; get reads the pixel word, then the palette entry of an
// index in use; assign compares palette entries (one entry compared per cycle);
// clear and fill write width * words per column (one pixel word written per
// cycle). A new request waits until the last result is in the output register.
// Reset clears control state and palette count; memories are not cleared.
module indexed_color_frame_buffer #(
  parameter int MAX_WIDTH     = 160,
  parameter int MAX_HEIGHT    = 128,
  parameter int INDEX_BITS    = 4,
  parameter int PALETTE_DEPTH = 15,
  parameter int WORD_BITS     = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [icfb_pkg::CMD_W-1:0]          in_cmd,
  input  logic [icfb_pkg::POS_W-1:0]          in_pos_x,
  input  logic [icfb_pkg::POS_W-1:0]          in_pos_y,
  input  logic [icfb_pkg::PIXIDX_W-1:0]       in_pixel_index,
  input  logic [icfb_pkg::COLOR_W-1:0]        in_rgb_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_out_of_range,
  output logic [icfb_pkg::PIXIDX_W-1:0]       out_result_index,
  output logic [icfb_pkg::COLOR_W-1:0]        out_result_color,
  output logic                                out_background_index,
  output logic                                out_drawing_active
);

  `include "indexed_color_frame_buffer_assert.svh"

  localparam int PPW         = WORD_BITS / INDEX_BITS;
  localparam int MAX_WPC     = (MAX_HEIGHT + PPW - 1) / PPW;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_WPC;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CTW         = $clog2(STORE_DEPTH + 1);
  localparam int RW          = (PPW > 1) ? $clog2(PPW) : 1;
  localparam int SHW         = $clog2(WORD_BITS);
  localparam int PAW         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(PALETTE_DEPTH + 1);
  localparam int RECIP       = (65536 + PPW - 1) / PPW;
  localparam int CW          = icfb_pkg::COLOR_W;
  localparam int RIW         = icfb_pkg::PIXIDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_PIXD  = 3'd3;
  localparam logic [2:0] S_PALD  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  function automatic logic [WORD_BITS-1:0] fill_word();
    logic [WORD_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < PPW; i++) begin
      p[i*INDEX_BITS] = 1'b1;
    end
    return p;
  endfunction

  // Division by the pixels-per-word constant through a 16-bit reciprocal;
  // exact for every numerator below 512.
  function automatic logic [8:0] div_ppw(input logic [8:0] n);
    logic [25:0] prod;
    prod = 26'(n) * 26'(RECIP);
    return prod[24:16];
  endfunction

  localparam logic [WORD_BITS-1:0] FILL_PATTERN = fill_word();
  localparam logic [WORD_BITS-1:0] PIX_MASK = WORD_BITS'((1 << INDEX_BITS) - 1);

  logic [WORD_BITS-1:0] pix_mem [STORE_DEPTH];
  logic [CW-1:0]        pal_mem [PALETTE_DEPTH];

  logic [2:0]            state_r, state_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic [INDEX_BITS-1:0] pix_r, pix_nxt;
  logic [CW-1:0]         color_r, color_nxt;
  logic                  oor_r, oor_nxt;
  logic [15:0]           mul_r, mul_nxt;
  logic [7:0]            q_r, q_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [CTW-1:0]        sweep_n_r, sweep_n_nxt;
  logic [CTW-1:0]        sweep_ctr_r, sweep_ctr_nxt;
  logic [PAW-1:0]        scan_i_r, scan_i_nxt;
  logic [CNT_W-1:0]      found_r, found_nxt;
  logic                  res_oor_r, res_oor_nxt;
  logic [RIW-1:0]        res_idx_r, res_idx_nxt;
  logic [CW-1:0]         res_col_r, res_col_nxt;
  logic [CNT_W-1:0]      pal_cnt_r, pal_cnt_nxt;
  logic                  bg_r, bg_nxt;
  logic                  draw_r, draw_nxt;
  logic [7:0]            width_r, width_nxt;
  logic [7:0]            height_r, height_nxt;
  logic [7:0]            wpc_r, wpc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_oor_r, out_oor_nxt;
  logic [RIW-1:0]        out_idx_r, out_idx_nxt;
  logic [CW-1:0]         out_col_r, out_col_nxt;
  logic                  out_bg_r, out_bg_nxt;
  logic                  out_draw_r, out_draw_nxt;

  logic                  pm_we, pm_re;
  logic [AW-1:0]         pm_addr;
  logic [WORD_BITS-1:0]  pm_wdata, pm_q;
  logic                  pal_we, pal_re;
  logic [PAW-1:0]        pal_addr;
  logic [CW-1:0]         pal_wdata, pal_q;

  logic                  accept;
  logic [7:0]            mul_a, height_cap;
  logic [8:0]            q9;
  logic [15:0]           qp;
  logic [31:0]           addr32;
  logic [CTW-1:0]        fill_n;
  logic [SHW-1:0]        shift;
  logic [WORD_BITS-1:0]  slot_mask;
  logic [INDEX_BITS-1:0] rd_idx;
  logic                  asn_fin;
  logic [CNT_W-1:0]      asn_found;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign out_valid            = out_valid_r;
  assign out_out_of_range     = out_oor_r;
  assign out_result_index     = out_idx_r;
  assign out_result_color     = out_col_r;
  assign out_background_index = out_bg_r;
  assign out_drawing_active   = out_draw_r;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pix_mem[pm_addr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_q <= pix_mem[pm_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_addr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_q <= pal_mem[pal_addr];
    end
  end

  always_comb begin
    mul_a = ((in_cmd == icfb_pkg::CMD_CLEAR) || (in_cmd == icfb_pkg::CMD_FILL)) ?
            width_r : in_pos_x;
    q9 = div_ppw(9'(in_pos_y));
    qp = 16'(q9[7:0]) * 16'(PPW);
    addr32 = 32'(mul_r) + 32'(q_r);
    if (32'(mul_r) >= 32'(STORE_DEPTH)) begin
      fill_n = CTW'(STORE_DEPTH);
    end else begin
      fill_n = CTW'(mul_r);
    end
    shift = SHW'(32'(rem_r) * INDEX_BITS);
    slot_mask = PIX_MASK << shift;
    rd_idx = INDEX_BITS'(pm_q >> shift);
    if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      height_cap = 8'(MAX_HEIGHT);
    end else begin
      height_cap = cfg_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pix_nxt       = pix_r;
    color_nxt     = color_r;
    oor_nxt       = oor_r;
    mul_nxt       = mul_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    sweep_n_nxt   = sweep_n_r;
    sweep_ctr_nxt = sweep_ctr_r;
    scan_i_nxt    = scan_i_r;
    found_nxt     = found_r;
    res_oor_nxt   = res_oor_r;
    res_idx_nxt   = res_idx_r;
    res_col_nxt   = res_col_r;
    pal_cnt_nxt   = pal_cnt_r;
    bg_nxt        = bg_r;
    draw_nxt      = draw_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    wpc_nxt       = wpc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_oor_nxt   = out_oor_r;
    out_idx_nxt   = out_idx_r;
    out_col_nxt   = out_col_r;
    out_bg_nxt    = out_bg_r;
    out_draw_nxt  = out_draw_r;
    pm_we         = 1'b0;
    pm_re         = 1'b0;
    pm_addr       = addr32[AW-1:0];
    pm_wdata      = (pm_q & ~slot_mask) | (WORD_BITS'(pix_r) << shift);
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    pal_addr      = '0;
    pal_wdata     = color_r;
    asn_fin       = 1'b0;
    asn_found     = found_r;

    if (cfg_valid) begin
      if (cfg_index == icfb_pkg::CFG_WIDTH) begin
        width_nxt = (32'(cfg_data) > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : cfg_data;
      end else if (cfg_index == icfb_pkg::CFG_HEIGHT) begin
        height_nxt = height_cap;
        wpc_nxt    = 8'(div_ppw(9'(height_cap) + 9'(PPW - 1)));
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          pix_nxt     = INDEX_BITS'(in_pixel_index);
          color_nxt   = in_rgb_color;
          oor_nxt     = (in_pos_x >= width_r) || (in_pos_y >= height_r);
          mul_nxt     = 16'(mul_a) * 16'(wpc_r);
          q_nxt       = q9[7:0];
          rem_nxt     = RW'(16'(in_pos_y) - qp);
          res_oor_nxt = 1'b0;
          res_idx_nxt = '0;
          res_col_nxt = '0;
          found_nxt   = '0;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        unique case (cmd_r) inside
          icfb_pkg::CMD_CLEAR, icfb_pkg::CMD_FILL: begin
            draw_nxt      = 1'b1;
            sweep_n_nxt   = fill_n;
            sweep_ctr_nxt = '0;
            state_nxt     = (fill_n != '0) ? S_SWEEP : S_DONE;
            if (cmd_r == icfb_pkg::CMD_FILL) begin
              bg_nxt      = 1'b1;
              pal_cnt_nxt = CNT_W'(1);
              pal_we      = 1'b1;
              pal_addr    = '0;
            end else begin
              bg_nxt      = 1'b0;
              pal_cnt_nxt = '0;
            end
          end
          icfb_pkg::CMD_PUT, icfb_pkg::CMD_GET: begin
            if (oor_r || (addr32 >= 32'(STORE_DEPTH))) begin
              res_oor_nxt = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              pm_re     = 1'b1;
              state_nxt = S_PIXD;
            end
          end
          icfb_pkg::CMD_ASSIGN: begin
            if (pal_cnt_r == '0) begin
              asn_fin = 1'b1;
            end else begin
              pal_re     = 1'b1;
              pal_addr   = '0;
              scan_i_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end
          icfb_pkg::CMD_END: begin
            draw_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SWEEP: begin
        pm_we    = 1'b1;
        pm_addr  = sweep_ctr_r[AW-1:0];
        pm_wdata = (cmd_r == icfb_pkg::CMD_FILL) ? FILL_PATTERN : '0;
        sweep_ctr_nxt = sweep_ctr_r + CTW'(1);
        if (sweep_ctr_nxt == sweep_n_r) begin
          state_nxt = S_DONE;
        end
      end
      S_PIXD: begin
        if (cmd_r == icfb_pkg::CMD_PUT) begin
          pm_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          res_idx_nxt = RIW'(rd_idx);
          if ((rd_idx != '0) && (32'(rd_idx) <= 32'(pal_cnt_r)) &&
              (32'(rd_idx) <= 32'(PALETTE_DEPTH))) begin
            pal_re    = 1'b1;
            pal_addr  = PAW'(32'(rd_idx) - 32'd1);
            state_nxt = S_PALD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PALD: begin
        res_col_nxt = pal_q;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        // The later match overwrites an earlier one, so the last one wins.
        if (pal_q == color_r) begin
          asn_found = CNT_W'(scan_i_r) + CNT_W'(1);
          found_nxt = asn_found;
        end
        if ((32'(scan_i_r) + 32'd1) < 32'(pal_cnt_r)) begin
          scan_i_nxt = scan_i_r + PAW'(1);
          pal_re     = 1'b1;
          pal_addr   = scan_i_nxt;
        end else begin
          asn_fin = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = res_oor_r;
          out_idx_nxt   = res_idx_r;
          out_col_nxt   = res_col_r;
          out_bg_nxt    = bg_r;
          out_draw_nxt  = draw_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Finish an assign: keep the match, or append when the palette has room.
    if (asn_fin) begin
      state_nxt = S_DONE;
      if (asn_found != '0) begin
        res_idx_nxt = RIW'(asn_found);
      end else if (32'(pal_cnt_r) < 32'(PALETTE_DEPTH)) begin
        pal_we      = 1'b1;
        pal_addr    = PAW'(pal_cnt_r);
        pal_cnt_nxt = pal_cnt_r + CNT_W'(1);
        res_idx_nxt = RIW'(pal_cnt_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pal_cnt_r   <= '0;
      bg_r        <= 1'b0;
      draw_r      <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      wpc_r       <= '0;
      out_valid_r <= 1'b0;
      sweep_ctr_r <= '0;
      sweep_n_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pal_cnt_r   <= pal_cnt_nxt;
      bg_r        <= bg_nxt;
      draw_r      <= draw_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      wpc_r       <= wpc_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_ctr_r <= sweep_ctr_nxt;
      sweep_n_r   <= sweep_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pix_r     <= pix_nxt;
    color_r   <= color_nxt;
    oor_r     <= oor_nxt;
    mul_r     <= mul_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    scan_i_r  <= scan_i_nxt;
    found_r   <= found_nxt;
    res_oor_r <= res_oor_nxt;
    res_idx_r <= res_idx_nxt;
    res_col_r <= res_col_nxt;
    out_oor_r <= out_oor_nxt;
    out_idx_r <= out_idx_nxt;
    out_col_r <= out_col_nxt;
    out_bg_r  <= out_bg_nxt;
    out_draw_r <= out_draw_nxt;
  end

  `ICFB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ICFB_ASSERT_SAME(a_sweep_in_bounds, state_r == S_SWEEP, sweep_ctr_r < sweep_n_r)
  `ICFB_ASSERT_NEXT(a_fill_sets_palette,
                    (state_r == S_CALC) && (cmd_r == icfb_pkg::CMD_FILL),
                    (pal_cnt_r == CNT_W'(1)) && bg_r && draw_r)

endmodule

// ----- tb/indexed_color_frame_buffer_tb.sv -----
// ---------------------------------------------------------------------------
// indexed_color_frame_buffer_tb
// Drives clear, fill, put, get, assign and end requests into the frame buffer
// under several image sizes, predicts every reply from a shadow copy of the
// pixel store and palette, and compares each reply field by field.
// ---------------------------------------------------------------------------
module indexed_color_frame_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 160;
  localparam int MAX_H        = 128;
  localparam int PIX_PER_WORD = 32 / icfb_pkg::PIXIDX_W;
  localparam int MAX_WPC      = (MAX_H + PIX_PER_WORD - 1) / PIX_PER_WORD;
  localparam int STORE_DEPTH  = MAX_W * MAX_WPC;
  localparam int PAL_DEPTH    = 15;
  localparam int CLK_PERIOD   = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [31:0] PIX_MASK = (32'd1 << icfb_pkg::PIXIDX_W) - 32'd1;

  // Command codes the block does not define; it must report status only.
  localparam logic [icfb_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [icfb_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd7;

  typedef struct {
    logic [icfb_pkg::CMD_W-1:0]    cmd;
    logic [icfb_pkg::POS_W-1:0]    x;
    logic [icfb_pkg::POS_W-1:0]    y;
    logic [icfb_pkg::PIXIDX_W-1:0] pix;
    logic [icfb_pkg::COLOR_W-1:0]  color;
  } fb_command_t;

  typedef struct {
    logic                          oor;
    logic [icfb_pkg::PIXIDX_W-1:0] index;
    logic [icfb_pkg::COLOR_W-1:0]  color;
    logic                          bg;
    logic                          drawing;
  } fb_reply_t;

  class frame_store_shadow_t;
    logic [31:0]                  words [STORE_DEPTH];
    bit                           word_written [STORE_DEPTH];
    logic [icfb_pkg::COLOR_W-1:0] palette [PAL_DEPTH];
    int unsigned                  palette_used;
    bit                           background;
    bit                           drawing;
    int unsigned                  width;
    int unsigned                  height;
    fb_reply_t                    owed[$];
    int                           mismatches;
    int                           commands, puts, gets, assigns, wipes, reg_writes;
    int                           oor_replies, full_palette_replies;

    function int unsigned words_per_column();
      return (height + PIX_PER_WORD - 1) / PIX_PER_WORD;
    endfunction

    function void write_reg(logic [icfb_pkg::CFG_IDX_W-1:0] idx,
                            logic [icfb_pkg::CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == icfb_pkg::CFG_WIDTH) begin
        width = (data > MAX_W) ? MAX_W : data;
      end else begin
        height = (data > MAX_H) ? MAX_H : data;
      end
    endfunction

    function bit locate(int unsigned x, int unsigned y,
                        output int unsigned word, output int unsigned shift);
      word = 0;
      shift = 0;
      if (x >= width || y >= height) return 0;
      word = x * words_per_column() + y / PIX_PER_WORD;
      if (word >= STORE_DEPTH) return 0;
      shift = (y % PIX_PER_WORD) * icfb_pkg::PIXIDX_W;
      return 1;
    endfunction

    // Out-of-range accesses touch no word, so they are always allowed.
    function bit can_touch(int unsigned x, int unsigned y);
      int unsigned w, sh;
      if (!locate(x, y, w, sh)) return 1;
      return word_written[w];
    endfunction

    function void wipe(logic [31:0] pattern);
      int unsigned n;
      n = width * words_per_column();
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      for (int unsigned i = 0; i < n; i++) begin
        words[i] = pattern;
        word_written[i] = 1;
      end
      wipes++;
    endfunction

    function void apply_command(fb_command_t c);
      fb_reply_t   r;
      int unsigned w, sh;
      logic [31:0] pattern;
      r = '{default: '0};
      commands++;
      case (c.cmd)
        icfb_pkg::CMD_CLEAR: begin
          palette_used = 0;
          background = 0;
          drawing = 1;
          wipe('0);
        end
        icfb_pkg::CMD_FILL: begin
          pattern = '0;
          for (int i = 0; i < PIX_PER_WORD; i++) begin
            pattern |= 32'd1 << (i * icfb_pkg::PIXIDX_W);
          end
          palette[0] = c.color;
          palette_used = 1;
          background = 1;
          drawing = 1;
          wipe(pattern);
        end
        icfb_pkg::CMD_PUT: begin
          puts++;
          if (locate(c.x, c.y, w, sh)) begin
            words[w] = (words[w] & ~(PIX_MASK << sh)) | ((32'(c.pix) & PIX_MASK) << sh);
          end else begin
            r.oor = 1;
          end
        end
        icfb_pkg::CMD_GET: begin
          gets++;
          if (locate(c.x, c.y, w, sh)) begin
            r.index = icfb_pkg::PIXIDX_W'((words[w] >> sh) & PIX_MASK);
            if (r.index != 0 && r.index <= palette_used) r.color = palette[r.index - 1];
          end else begin
            r.oor = 1;
          end
        end
        icfb_pkg::CMD_ASSIGN: begin
          assigns++;
          // The last matching entry wins, so the scan runs to the end.
          for (int unsigned i = 0; i < palette_used; i++) begin
            if (palette[i] == c.color) r.index = icfb_pkg::PIXIDX_W'(i + 1);
          end
          if (r.index == 0 && palette_used < PAL_DEPTH) begin
            palette[palette_used] = c.color;
            palette_used++;
            r.index = icfb_pkg::PIXIDX_W'(palette_used);
          end
          if (r.index == 0) full_palette_replies++;
        end
        icfb_pkg::CMD_END: begin
          drawing = 0;
        end
        default: begin
        end
      endcase
      if (r.oor) oor_replies++;
      r.bg = background;
      r.drawing = drawing;
      owed.push_back(r);
    endfunction

    function void report(string field, logic [icfb_pkg::COLOR_W-1:0] want,
                         logic [icfb_pkg::COLOR_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endfunction

    function void check_reply(fb_reply_t got);
      fb_reply_t want;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: reply with no request outstanding, expected none, got index %h color %h",
                 $realtime, got.index, got.color);
        return;
      end
      want = owed.pop_front();
      if (got.oor !== want.oor) report("out_of_range", want.oor, got.oor);
      if (got.index !== want.index) report("result_index", want.index, got.index);
      if (got.color !== want.color) report("result_color", want.color, got.color);
      if (got.bg !== want.bg) report("background_index", want.bg, got.bg);
      if (got.drawing !== want.drawing) report("drawing_active", want.drawing, got.drawing);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [icfb_pkg::CFG_IDX_W-1:0]  cfg_index = icfb_pkg::CFG_WIDTH;
  logic [icfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [icfb_pkg::CMD_W-1:0]      in_cmd = icfb_pkg::CMD_END;
  logic [icfb_pkg::POS_W-1:0]      in_pos_x = '0;
  logic [icfb_pkg::POS_W-1:0]      in_pos_y = '0;
  logic [icfb_pkg::PIXIDX_W-1:0]   in_pixel_index = '0;
  logic [icfb_pkg::COLOR_W-1:0]    in_rgb_color = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_out_of_range;
  logic [icfb_pkg::PIXIDX_W-1:0]   out_result_index;
  logic [icfb_pkg::COLOR_W-1:0]    out_result_color;
  logic                            out_background_index;
  logic                            out_drawing_active;

  logic                            idle_enable = 1'b1;
  logic                            hold_trigger = 1'b0;
  logic                            hold_seen = 1'b0;
  int unsigned                     hold_left = 0;

  frame_store_shadow_t shadow = new();

  indexed_color_frame_buffer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_pixel_index       (in_pixel_index),
    .in_rgb_color         (in_rgb_color),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_out_of_range     (out_out_of_range),
    .out_result_index     (out_result_index),
    .out_result_color     (out_result_color),
    .out_background_index (out_background_index),
    .out_drawing_active   (out_drawing_active)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Reply side: check what was accepted at this edge, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_reply('{oor: out_out_of_range, index: out_result_index,
                           color: out_result_color, bg: out_background_index,
                           drawing: out_drawing_active});
    end
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_enable || ($urandom_range(99) >= 30);
    end
  end

  function automatic fb_command_t make_command(logic [icfb_pkg::CMD_W-1:0] cmd,
                                               int unsigned x, int unsigned y,
                                               int unsigned pix,
                                               logic [icfb_pkg::COLOR_W-1:0] color);
    fb_command_t c;
    c.cmd = cmd;
    c.x = icfb_pkg::POS_W'(x);
    c.y = icfb_pkg::POS_W'(y);
    c.pix = icfb_pkg::PIXIDX_W'(pix);
    c.color = color;
    return c;
  endfunction

  function automatic logic [icfb_pkg::COLOR_W-1:0] pick_color();
    // An odd multiplier keeps the pooled colors distinct, so assigns both
    // hit earlier entries and keep appending until the palette is full.
    if ($urandom_range(99) < 60) begin
      return icfb_pkg::COLOR_W'(24'h0F1E2D * $urandom_range(19));
    end
    return icfb_pkg::COLOR_W'($urandom());
  endfunction

  function automatic logic [icfb_pkg::POS_W-1:0] pick_coord(int unsigned limit);
    if (limit != 0 && $urandom_range(99) < 80) begin
      return icfb_pkg::POS_W'($urandom_range(limit - 1));
    end
    if ($urandom_range(1) == 1) return icfb_pkg::POS_W'(limit);
    return icfb_pkg::POS_W'($urandom_range(255));
  endfunction

  function automatic fb_command_t random_command();
    fb_command_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 34) c.cmd = icfb_pkg::CMD_PUT;
    else if (roll < 64) c.cmd = icfb_pkg::CMD_GET;
    else if (roll < 89) c.cmd = icfb_pkg::CMD_ASSIGN;
    else if (roll < 91) c.cmd = icfb_pkg::CMD_CLEAR;
    else if (roll < 93) c.cmd = icfb_pkg::CMD_FILL;
    else if (roll < 97) c.cmd = icfb_pkg::CMD_END;
    else c.cmd = (roll % 2) ? CMD_RSVD_A : CMD_RSVD_B;
    c.x = pick_coord(shadow.width);
    c.y = pick_coord(shadow.height);
    c.pix = icfb_pkg::PIXIDX_W'($urandom_range(15));
    c.color = pick_color();
    // A pixel word that was never written must not be read; wipe the image instead.
    if ((c.cmd == icfb_pkg::CMD_PUT || c.cmd == icfb_pkg::CMD_GET) &&
        !shadow.can_touch(c.x, c.y)) begin
      c.cmd = ($urandom_range(1) == 1) ? icfb_pkg::CMD_FILL : icfb_pkg::CMD_CLEAR;
    end
    return c;
  endfunction

  task automatic send_command(fb_command_t c);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(99) < 30) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_pos_x <= c.x;
    in_pos_y <= c.y;
    in_pixel_index <= c.pix;
    in_rgb_color <= c.color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.apply_command(c);
  endtask

  // Replies are counted at the falling edge, away from the reply checker.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (shadow.owed.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_image_size(logic [icfb_pkg::CFG_DATA_W-1:0] w,
                                logic [icfb_pkg::CFG_DATA_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= icfb_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.write_reg(icfb_pkg::CFG_WIDTH, w);
    cfg_index <= icfb_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.write_reg(icfb_pkg::CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on a 5 x 10 image, so a column spans two words.
    set_image_size(8'd5, 8'd10);
    send_command(make_command(icfb_pkg::CMD_END, 0, 0, 0, '0));
    send_command(make_command(CMD_RSVD_A, 0, 0, 0, '0));
    send_command(make_command(icfb_pkg::CMD_CLEAR, 0, 0, 0, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 0, 0, 15, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 4, 9, 1, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 5, 0, 3, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 0, 10, 3, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 255, 255, 15, 24'hFFFFFF));
    send_command(make_command(icfb_pkg::CMD_GET, 0, 0, 0, '0));
    send_command(make_command(icfb_pkg::CMD_GET, 4, 9, 0, '0));
    send_command(make_command(icfb_pkg::CMD_GET, 1, 8, 0, '0));
    send_command(make_command(icfb_pkg::CMD_GET, 255, 255, 0, '0));
    send_command(make_command(icfb_pkg::CMD_GET, 4, 10, 0, '0));
    send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0, 24'hFFFFFF));
    send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0, 24'h000000));
    send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0, 24'hFFFFFF));
    send_command(make_command(icfb_pkg::CMD_GET, 4, 9, 0, '0));
    send_command(make_command(icfb_pkg::CMD_FILL, 0, 0, 0, 24'hABCDEF));
    send_command(make_command(icfb_pkg::CMD_GET, 3, 7, 0, '0));
    send_command(make_command(icfb_pkg::CMD_PUT, 2, 8, 0, '0));
    send_command(make_command(icfb_pkg::CMD_GET, 2, 8, 0, '0));
    send_command(make_command(CMD_RSVD_B, 255, 255, 15, 24'hFFFFFF));
    send_command(make_command(icfb_pkg::CMD_END, 0, 0, 0, '0));
    // Fill the palette to its last entry, then overflow it.
    for (int k = 0; k < PAL_DEPTH - 1; k++) begin
      send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0,
                                icfb_pkg::COLOR_W'(24'h100000 + k)));
    end
    send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0, 24'h123456));
    send_command(make_command(icfb_pkg::CMD_ASSIGN, 0, 0, 0, 24'hABCDEF));

    for (int p = 0; p < 14; p++) begin
      logic [icfb_pkg::CFG_DATA_W-1:0] w, h;
      int unsigned count;
      case (p)
        0: begin w = 8'hFF; h = 8'hFF; count = 50; end
        1: begin w = 8'd0; h = 8'd40; count = 40; end
        2: begin w = 8'd12; h = 8'd0; count = 40; end
        3: begin w = 8'd1; h = 8'd1; count = 60; end
        4: begin
          w = icfb_pkg::CFG_DATA_W'(MAX_W);
          h = icfb_pkg::CFG_DATA_W'(MAX_H);
          count = 40;
        end
        default: begin
          w = icfb_pkg::CFG_DATA_W'($urandom_range(1, 24));
          h = icfb_pkg::CFG_DATA_W'($urandom_range(1, 40));
          count = 140;
        end
      endcase
      drain_replies();
      set_image_size(w, h);
      idle_enable <= !(p == 8 || p == 9);
      if ($urandom_range(1) == 1) begin
        send_command(make_command(($urandom_range(1) == 1) ? icfb_pkg::CMD_FILL :
                                  icfb_pkg::CMD_CLEAR, 0, 0, 0, pick_color()));
      end
      for (int unsigned i = 0; i < count; i++) begin
        if (p == 6 && i == 20) hold_trigger <= ~hold_trigger;
        if (p == 7 && i == 70) drain_replies();
        send_command(random_command());
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d puts, %0d gets, %0d assigns, %0d clears or fills.",
             shadow.commands, shadow.puts, shadow.gets, shadow.assigns, shadow.wipes);
    $display("%0d size register writes, %0d out-of-range replies, %0d full-palette replies.",
             shadow.reg_writes, shadow.oor_replies, shadow.full_palette_replies);
    if (shadow.mismatches == 0 && shadow.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule
